// ===== rtl/lsac_pkg.sv =====
`timescale 1ns / 1ps
package lsac_pkg;

  localparam logic [7:0] FULL_ALPHA = 8'd255;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [8:0] opacity_q8;
    logic       present;
    logic       first_layer;
    logic       last_layer;
  } lsac_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } lsac_out_t;

  typedef enum logic [1:0] {
    OP_SKIP    = 2'd0,
    OP_REPLACE = 2'd1,
    OP_MIX     = 2'd2
  } lsac_op_t;

  typedef struct packed {
    lsac_op_t   op;
    logic [7:0] ea;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       first_layer;
    logic       last_layer;
  } lsac_cmd_t;

  // exact x / 255 for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
    return {8'd0, a} * {8'd0, b};
  endfunction

endpackage

// ===== rtl/lsac_front.sv =====
`timescale 1ns / 1ps
module lsac_front (
  input  lsac_pkg::lsac_in_t  sample,
  output lsac_pkg::lsac_cmd_t cmd
);
  import lsac_pkg::*;

  logic [16:0] prod;
  logic [8:0]  ea_raw;
  logic [7:0]  ea;

  always_comb begin
    prod   = {9'd0, sample.alpha} * {8'd0, sample.opacity_q8};
    ea_raw = prod[16:8];
    // opacity above full saturates
    ea     = (ea_raw > {1'b0, FULL_ALPHA}) ? FULL_ALPHA : ea_raw[7:0];

    cmd.ea          = ea;
    cmd.red         = sample.red;
    cmd.green       = sample.green;
    cmd.blue        = sample.blue;
    cmd.first_layer = sample.first_layer;
    cmd.last_layer  = sample.last_layer;
    if (!sample.present || ea == 8'd0) begin
      cmd.op = OP_SKIP;
    end else if (ea == FULL_ALPHA) begin
      cmd.op = OP_REPLACE;
    end else begin
      cmd.op = OP_MIX;
    end
  end

endmodule

// ===== rtl/lsac_queue.sv =====
`timescale 1ns / 1ps
module lsac_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lsac_pkg::lsac_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output lsac_pkg::lsac_cmd_t pop_data
);
  import lsac_pkg::*;

  lsac_cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;
  logic                     do_push;
  logic                     do_pop;

  assign full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/lsac_back.sv =====
`timescale 1ns / 1ps
module lsac_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  lsac_pkg::lsac_cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lsac_pkg::lsac_out_t out_data
);
  import lsac_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_DIV  = 2'b10
  } lsac_state_t;

  lsac_state_t state;
  lsac_state_t state_next;
  lsac_out_t   acc;
  lsac_out_t   acc_next;
  lsac_out_t   base;
  lsac_out_t   mixed;
  logic        emit;
  logic        load_sums;
  logic        out_free;
  logic        can_finish;
  logic [7:0]  inv;

  // products registered between the ST_LOAD and ST_DIV steps of a mix
  logic [15:0] sum_red;
  logic [15:0] sum_green;
  logic [15:0] sum_blue;
  logic [15:0] prod_alpha;
  logic [7:0]  ea_r;
  logic        last_r;

  assign out_free   = !out_valid || out_ready;
  assign can_finish = !cmd.last_layer || out_free;
  assign base       = cmd.first_layer ? '0 : acc;
  assign inv        = FULL_ALPHA - cmd.ea;

  always_comb begin
    mixed.out_red   = div255(sum_red);
    mixed.out_green = div255(sum_green);
    mixed.out_blue  = div255(sum_blue);
    mixed.out_alpha = ea_r + div255(prod_alpha);
  end

  always_comb begin
    state_next = state;
    acc_next   = acc;
    emit       = 1'b0;
    cmd_pop    = 1'b0;
    load_sums  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_REPLACE: begin
              if (can_finish) begin
                cmd_pop  = 1'b1;
                acc_next = '{out_red: cmd.red, out_green: cmd.green,
                             out_blue: cmd.blue, out_alpha: FULL_ALPHA};
                emit     = cmd.last_layer;
              end
            end
            OP_MIX: begin
              cmd_pop    = 1'b1;
              load_sums  = 1'b1;
              state_next = ST_DIV;
            end
            default: begin
              if (can_finish) begin
                cmd_pop  = 1'b1;
                acc_next = base;
                emit     = cmd.last_layer;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (!last_r || out_free) begin
          acc_next   = mixed;
          emit       = last_r;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_sums) begin
      sum_red    <= mul8(cmd.red, cmd.ea) + mul8(base.out_red, inv);
      sum_green  <= mul8(cmd.green, cmd.ea) + mul8(base.out_green, inv);
      sum_blue   <= mul8(cmd.blue, cmd.ea) + mul8(base.out_blue, inv);
      prod_alpha <= mul8(base.out_alpha, inv);
      ea_r       <= cmd.ea;
      last_r     <= cmd.last_layer;
    end
    if (emit) begin
      out_data <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/layer_stack_alpha_compositor.sv =====
`timescale 1ns / 1ps
// a last-layer sample shows its pixel on out_valid after the command queue and the output
// register; a weighted blend also passes the product registers between ST_LOAD and ST_DIV
// throughput: 1 sample per cycle for skipped or opaque samples while the output is not
// stalled; a blended sample holds the accumulator loop through the product and divide-by-255 stages
// a 2-entry command queue lets input transfers continue while the blend stage works
// reset clears the accumulator to transparent black, empties the queue, drops out_valid
module layer_stack_alpha_compositor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsac_pkg::lsac_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lsac_pkg::lsac_out_t out_data
);
  import lsac_pkg::*;

  lsac_cmd_t front_cmd;
  lsac_cmd_t back_cmd;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;

  assign in_ready = !q_full;

  lsac_front u_front (
    .sample (in_data),
    .cmd    (front_cmd)
  );

  lsac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (back_cmd)
  );

  lsac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (back_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/lsac_checker.sv =====
`timescale 1ns / 1ps
module lsac_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lsac_pkg::lsac_out_t out_data
);
  import lsac_pkg::*;

  // after reset the queue is empty and nothing is pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("queue or output not cleared by reset");

  // zero alpha means nothing was blended since the last clear
  a_clear_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.out_alpha == 8'd0) |->
      (out_data.out_red == 8'd0 && out_data.out_green == 8'd0 &&
       out_data.out_blue == 8'd0))
    else $error("transparent pixel carries color");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("stalled output changed");

endmodule

bind layer_stack_alpha_compositor lsac_checker u_lsac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tb_layer_stack_alpha_compositor.sv =====
`timescale 1ns / 1ps
module tb_layer_stack_alpha_compositor;
  import lsac_pkg::*;

  localparam int ITEM_TARGET    = 650;
  localparam int HOLD_OFF       = 120;
  localparam int DRAIN_CYCLES   = 8;
  localparam int QUIET_LIMIT    = 1000;
  localparam int REPORT_LIMIT   = 10;

  class pixel_scoreboard;
    lsac_out_t   acc;
    lsac_out_t   expected_pixels[$];
    int unsigned failures;

    function new();
      acc = '0;
      failures = 0;
    endfunction

    function logic [7:0] weigh_channel(logic [7:0] top, logic [7:0] under,
                                       int unsigned ea);
      int unsigned sum;
      sum = 32'(top) * ea + 32'(under) * (32'(FULL_ALPHA) - ea);
      return 8'(sum / 32'(FULL_ALPHA));
    endfunction

    function void note_sample(lsac_in_t s);
      int unsigned ea;
      int unsigned inv;
      if (s.first_layer) begin
        acc = '0;
      end
      if (s.present && s.alpha != 8'd0) begin
        ea = (32'(s.alpha) * 32'(s.opacity_q8)) >> 8;
        // opacity above full can push the product past opaque
        if (ea > 32'(FULL_ALPHA)) begin
          ea = 32'(FULL_ALPHA);
        end
        if (ea == 32'(FULL_ALPHA)) begin
          acc.out_red   = s.red;
          acc.out_green = s.green;
          acc.out_blue  = s.blue;
          acc.out_alpha = FULL_ALPHA;
        end else if (ea != 0) begin
          inv = 32'(FULL_ALPHA) - ea;
          acc.out_red   = weigh_channel(s.red, acc.out_red, ea);
          acc.out_green = weigh_channel(s.green, acc.out_green, ea);
          acc.out_blue  = weigh_channel(s.blue, acc.out_blue, ea);
          acc.out_alpha = 8'(ea + (32'(acc.out_alpha) * inv) / 32'(FULL_ALPHA));
        end
      end
      if (s.last_layer) begin
        expected_pixels = {expected_pixels, acc};
      end
    endfunction

    function void check_pixel(lsac_out_t got);
      lsac_out_t want;
      if (expected_pixels.size() == 0) begin
        if (failures < REPORT_LIMIT) begin
          $display("%0t: pixel with nothing pending: r=%0d g=%0d b=%0d a=%0d", $realtime,
                   got.out_red, got.out_green, got.out_blue, got.out_alpha);
        end
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        if (failures < REPORT_LIMIT) begin
          $display({"%0t: pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d, ",
                    "got r=%0d g=%0d b=%0d a=%0d"},
                   $realtime, want.out_red, want.out_green, want.out_blue, want.out_alpha,
                   got.out_red, got.out_green, got.out_blue, got.out_alpha);
        end
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lsac_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lsac_out_t out_data;

  pixel_scoreboard sb = new();
  int unsigned     quiet_cycles = 0;
  int unsigned     layers_sent = 0;
  int unsigned     burst_left = 0;
  bit              hold_off_req = 1'b0;

  layer_stack_alpha_compositor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // transfers seen on both channels, and the stall count for the watchdog
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_sample(in_data);
    end
    if (!rst && out_valid && out_ready) begin
      sb.check_pixel(out_data);
    end
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // receiver: picks a new stall pattern for each random span, long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 60);
      end
      span--;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 99) < 60);
        end
        2: begin
          out_ready <= (span % 3 == 0);
        end
        default: begin
          out_ready <= ($urandom_range(0, 99) < 20);
        end
      endcase
    end
  end

  function automatic lsac_in_t layer_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a, logic [8:0] op, logic present,
                                            logic first, logic last);
    lsac_in_t s;
    s.red = r;
    s.green = g;
    s.blue = b;
    s.alpha = a;
    s.opacity_q8 = op;
    s.present = present;
    s.first_layer = first;
    s.last_layer = last;
    return s;
  endfunction

  task automatic send_layer(lsac_in_t s);
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    layers_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // now and then a long stretch without gaps
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
    end
  endtask

  task automatic wait_results_done();
    // let the monitor note the last input transfer first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned depth;
    int unsigned pick;
    bit          hold_done;
    bit          pause_done;
    lsac_in_t    s;
    logic [63:0] noise;
    hold_done = 1'b0;
    pause_done = 1'b0;
    burst_left = $urandom_range(1, 20);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: blend over the reset pixel with no first flag
    send_layer(layer_sample(8'd200, 8'd100, 8'd50, 8'd128, 9'd256, 1'b1, 1'b0, 1'b1));
    // first and last together, opaque
    send_layer(layer_sample(8'd255, 8'd255, 8'd255, 8'd255, 9'd256, 1'b1, 1'b1, 1'b1));
    // opaque base, then near-zero and zero effective alpha
    send_layer(layer_sample(8'd0, 8'd255, 8'd0, 8'd255, 9'd256, 1'b1, 1'b1, 1'b0));
    send_layer(layer_sample(8'd255, 8'd0, 8'd255, 8'd1, 9'd256, 1'b1, 1'b0, 1'b0));
    send_layer(layer_sample(8'd255, 8'd0, 8'd255, 8'd1, 9'd255, 1'b1, 1'b0, 1'b0));
    send_layer(layer_sample(8'd255, 8'd255, 8'd255, 8'd255, 9'd0, 1'b1, 1'b0, 1'b1));
    // opacity above full, with and without saturation
    send_layer(layer_sample(8'd10, 8'd20, 8'd30, 8'd255, 9'd511, 1'b1, 1'b1, 1'b1));
    send_layer(layer_sample(8'd90, 8'd80, 8'd70, 8'd200, 9'd257, 1'b1, 1'b1, 1'b0));
    send_layer(layer_sample(8'd1, 8'd2, 8'd3, 8'd255, 9'd300, 1'b1, 1'b0, 1'b1));
    send_layer(layer_sample(8'd170, 8'd85, 8'd240, 8'd2, 9'd400, 1'b1, 1'b1, 1'b1));
    // absent samples: flags still act
    send_layer(layer_sample(8'd255, 8'd255, 8'd255, 8'd255, 9'd256, 1'b0, 1'b1, 1'b1));
    send_layer(layer_sample(8'd50, 8'd60, 8'd70, 8'd255, 9'd256, 1'b1, 1'b1, 1'b0));
    send_layer(layer_sample(8'd255, 8'd255, 8'd255, 8'd255, 9'd256, 1'b0, 1'b0, 1'b0));
    // zero alpha while present
    send_layer(layer_sample(8'd255, 8'd0, 8'd0, 8'd0, 9'd256, 1'b1, 1'b0, 1'b1));
    // weighted blends at color extremes
    send_layer(layer_sample(8'd0, 8'd0, 8'd0, 8'd255, 9'd256, 1'b1, 1'b1, 1'b0));
    send_layer(layer_sample(8'd255, 8'd255, 8'd255, 8'd128, 9'd256, 1'b1, 1'b0, 1'b0));
    send_layer(layer_sample(8'd0, 8'd255, 8'd0, 8'd254, 9'd256, 1'b1, 1'b0, 1'b0));
    send_layer(layer_sample(8'd255, 8'd0, 8'd255, 8'd255, 9'd255, 1'b1, 1'b0, 1'b1));
    send_layer(layer_sample(8'd123, 8'd45, 8'd67, 8'd77, 9'd128, 1'b1, 1'b1, 1'b0));
    send_layer(layer_sample(8'd89, 8'd210, 8'd3, 8'd190, 9'd1, 1'b1, 1'b0, 1'b0));
    send_layer(layer_sample(8'd255, 8'd128, 8'd1, 8'd100, 9'd200, 1'b1, 1'b0, 1'b1));
    // no first flag across pixels: keeps the previous accumulator
    send_layer(layer_sample(8'd0, 8'd0, 8'd255, 8'd60, 9'd256, 1'b1, 1'b0, 1'b1));

    while (layers_sent < ITEM_TARGET) begin
      if (!hold_done && layers_sent >= 200) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && layers_sent >= 420) begin
        in_valid <= 1'b0;
        wait_results_done();
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        depth = $urandom_range(1, 6);
        for (int unsigned k = 0; k < depth; k++) begin
          s.red = 8'($urandom);
          s.green = 8'($urandom);
          s.blue = 8'($urandom);
          pick = $urandom_range(0, 99);
          s.alpha = (pick < 15) ? 8'd0 : (pick < 35) ? 8'd255 : 8'($urandom_range(1, 254));
          pick = $urandom_range(0, 99);
          s.opacity_q8 = (pick < 15) ? 9'd256 : (pick < 25) ? 9'd0 :
                         (pick < 35) ? 9'($urandom_range(257, 511)) :
                         9'($urandom_range(1, 255));
          s.present = ($urandom_range(0, 99) < 85);
          s.first_layer = (k == 0);
          s.last_layer = (k == depth - 1);
          send_layer(s);
        end
      end else begin
        // noise: every field and flag at random
        noise = {$urandom, $urandom};
        s = noise[$bits(lsac_in_t)-1:0];
        send_layer(s);
      end
    end

    in_valid <= 1'b0;
    wait_results_done();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
